@@ src/jdcm_pkg.sv @@
// ----------------------------------------------------------------------------
// jdcm_pkg: shared types and constants of the joystick conditioner
// Beat payload structs, configuration register indexes, operation and
// result kind codes, and widths of the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package jdcm_pkg;

    localparam int ADC_BITS   = 10;
    localparam int TICK_W     = 16;
    localparam int PCT        = 100;
    // Quotient bits of the divider; the top bit flags a quotient above 127.
    localparam int QW         = 8;
    // Numerator magnitude: a raw distance times one hundred.
    localparam int NUM_W      = ADC_BITS + QW - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = $clog2(QW);

    localparam logic [ADC_BITS-1:0] ANALOG_MAX = {ADC_BITS{1'b1}};
    localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0]   TICKS_RST  = TICK_W'(5000);
    localparam logic [QW-1:0]       PCT_Q      = QW'(PCT);

    // Operation codes.
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_CAL_DONE = 2'd1;
    localparam logic [1:0] KIND_READING  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CAL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE_TKS = 3'd5;

    typedef struct packed {
        logic [1:0]          op;
        logic [ADC_BITS-1:0] raw_x;
        logic [ADC_BITS-1:0] raw_y;
        logic                button_in;
        logic [ADC_BITS-1:0] load_min_x;
        logic [ADC_BITS-1:0] load_max_x;
        logic [ADC_BITS-1:0] load_min_y;
        logic [ADC_BITS-1:0] load_max_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ADC_BITS-1:0] value_x;
        logic [ADC_BITS-1:0] value_y;
        logic signed [7:0]   position_x;
        logic signed [7:0]   position_y;
        logic                button_out;
        logic                is_calibrated;
        logic                moved;
        logic [ADC_BITS-1:0] band_min_x;
        logic [ADC_BITS-1:0] band_max_x;
        logic [ADC_BITS-1:0] band_min_y;
        logic [ADC_BITS-1:0] band_max_y;
    } out_item_t;

    // Lane 0 is the X axis, lane 1 the Y axis.
    typedef struct packed {
        logic [1:0][ADC_BITS-1:0] axis_min;
        logic [1:0][ADC_BITS-1:0] axis_max;
        logic                     auto_cal;
        logic [TICK_W-1:0]        cal_ticks;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic reading;
    } status_t;

endpackage

`default_nettype wire

@@ src/jdcm_dpath.sv @@
// ----------------------------------------------------------------------------
// jdcm_dpath: datapath of the joystick conditioner
// Holds the captured beat, the dead band and calibration state, two lanes
// of restoring dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcm_dpath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  jdcm_pkg::cfg_t       cfg,
    input  jdcm_pkg::in_item_t   in_item,
    input  jdcm_pkg::cmd_t       cmd,
    output jdcm_pkg::status_t    status,
    output jdcm_pkg::out_item_t  out_item
);
    import jdcm_pkg::*;

    in_item_t                 item_reg;
    out_item_t                out_reg;
    out_item_t                out_next;

    logic [1:0][ADC_BITS-1:0] lo_reg, lo_next;
    logic [1:0][ADC_BITS-1:0] hi_reg, hi_next;
    logic                     done_reg, done_next;
    logic [TICK_W-1:0]        elapsed_reg, elapsed_next;
    logic                     seen_reg, seen_next;
    logic [1:0][7:0]          last_reg, last_next;

    logic [1:0][NUM_W-1:0]    rem_reg, rem_next;
    logic [1:0][NUM_W-1:0]    dsr_reg, dsr_next;
    logic [1:0][QW-1:0]       q_reg, q_next;
    logic [1:0]               neg_reg, neg_next;
    logic [1:0]               zero_reg, zero_next;

    logic [1:0][ADC_BITS-1:0] raw;
    logic [1:0][ADC_BITS-1:0] diff;
    logic [1:0][NUM_W-1:0]    num;
    logic [1:0][ADC_BITS:0]   span_lo;
    logic [1:0][ADC_BITS:0]   span_hi;
    logic [1:0][ADC_BITS:0]   den;
    logic [1:0][ADC_BITS-1:0] den_abs;
    logic [1:0]               in_band;
    logic [1:0]               below;
    logic [1:0][QW-1:0]       mag;
    logic [1:0][7:0]          pos;
    logic                     calibrating;
    logic                     moved;

    assign raw         = {item_reg.raw_y, item_reg.raw_x};
    assign calibrating = cfg.auto_cal && !done_reg;
    assign status.reading = (item_reg.op == OP_SAMPLE) && !calibrating;

    // Per-lane setup: classify against the band and form the operands.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            in_band[l] = (raw[l] >= lo_reg[l]) && (raw[l] <= hi_reg[l]);
            below[l]   = raw[l] < lo_reg[l];
            span_lo[l] = {1'b0, lo_reg[l]} - {1'b0, cfg.axis_min[l]};
            span_hi[l] = {1'b0, cfg.axis_max[l]} - {1'b0, hi_reg[l]};
            diff[l]    = below[l] ? (lo_reg[l] - raw[l]) : (raw[l] - hi_reg[l]);
            num[l]     = (NUM_W'(diff[l]) << 6) + (NUM_W'(diff[l]) << 5)
                       + (NUM_W'(diff[l]) << 2);
            den[l]     = below[l] ? span_lo[l] : span_hi[l];
            den_abs[l] = den[l][ADC_BITS] ? ADC_BITS'(-den[l])
                                          : den[l][ADC_BITS-1:0];
        end
    end

    // Divider lanes: load on prep, one restoring step per cycle while step is set.
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.prep)
            begin
                rem_next[l]  = num[l];
                dsr_next[l]  = {den_abs[l], {(QW-1){1'b0}}};
                q_next[l]    = '0;
                neg_next[l]  = below[l] ^ den[l][ADC_BITS];
                zero_next[l] = in_band[l] || (span_lo[l] == '0) || (span_hi[l] == '0);
            end
            else if (cmd.step)
            begin
                if (rem_reg[l] >= dsr_reg[l])
                begin
                    rem_next[l] = rem_reg[l] - dsr_reg[l];
                    q_next[l]   = {q_reg[l][QW-2:0], 1'b1};
                end
                else
                begin
                    q_next[l]   = {q_reg[l][QW-2:0], 1'b0};
                end
                dsr_next[l] = dsr_reg[l] >> 1;
            end
        end
    end

    // Clamp to one hundred percent, give zero where flagged and apply the sign.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l] = (q_reg[l][QW-1] || (q_reg[l] > PCT_Q)) ? PCT_Q : q_reg[l];
            if (zero_reg[l])
                pos[l] = '0;
            else if (neg_reg[l])
                pos[l] = 8'(-mag[l]);
            else
                pos[l] = 8'(mag[l]);
        end
    end

    assign moved = !seen_reg || (pos[0] != last_reg[0]) || (pos[1] != last_reg[1]);

    // Item effect on the block state and the result it gives.
    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        done_next    = done_reg;
        elapsed_next = elapsed_reg;
        seen_next    = seen_reg;
        last_next    = last_reg;
        out_next     = '0;
        out_next.kind = KIND_ACK;
        case (item_reg.op)
            OP_SAMPLE:
            begin
                if (calibrating)
                begin
                    if (elapsed_reg >= cfg.cal_ticks)
                    begin
                        done_next     = 1'b1;
                        elapsed_next  = '0;
                        out_next.kind = KIND_CAL_DONE;
                    end
                    else
                    begin
                        for (int l = 0; l < 2; l++)
                        begin
                            if (raw[l] > hi_reg[l])
                                hi_next[l] = raw[l];
                            if (raw[l] < lo_reg[l])
                                lo_next[l] = raw[l];
                        end
                    end
                end
                else
                begin
                    out_next.kind       = KIND_READING;
                    out_next.value_x    = item_reg.raw_x;
                    out_next.value_y    = item_reg.raw_y;
                    out_next.position_x = pos[0];
                    out_next.position_y = pos[1];
                    out_next.button_out = item_reg.button_in;
                    out_next.moved      = moved;
                    if (moved)
                        last_next = pos;
                    seen_next = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (calibrating && (elapsed_reg != TICK_MAX))
                    elapsed_next = elapsed_reg + 1'b1;
            end
            OP_RESTART:
            begin
                done_next    = 1'b0;
                elapsed_next = '0;
            end
            OP_LOAD:
            begin
                lo_next = {item_reg.load_min_y, item_reg.load_min_x};
                hi_next = {item_reg.load_max_y, item_reg.load_max_x};
            end
            default:
            begin
                out_next.kind = KIND_ACK;
            end
        endcase
        out_next.is_calibrated = done_next;
        out_next.band_min_x    = lo_next[0];
        out_next.band_max_x    = hi_next[0];
        out_next.band_min_y    = lo_next[1];
        out_next.band_max_y    = hi_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg      <= {ANALOG_MAX, ANALOG_MAX};
            hi_reg      <= '0;
            done_reg    <= 1'b0;
            elapsed_reg <= '0;
            seen_reg    <= 1'b0;
            last_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            done_reg    <= done_next;
            elapsed_reg <= elapsed_next;
            seen_reg    <= seen_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
        if (cmd.commit)
            out_reg <= out_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

@@ src/jdcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// jdcm_ctrl: sequencer of the joystick conditioner
// Takes one beat at a time, runs the divider steps for readings and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcm_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire                out_stall,
    input  jdcm_pkg::status_t  status,
    output jdcm_pkg::cmd_t     cmd
);
    import jdcm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                if (status.reading)
                begin
                    cmd.prep   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PREP))
        else $error("accepted beat did not start processing");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == LAST_STEP) |=> (state_reg == S_PUSH))
        else $error("divider did not finish after its last step");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid && state_reg == S_IDLE))
        else $error("committed result not presented");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |-> $past(in_valid && !in_stall))
        else $error("processing began without an accepted beat");
`endif

endmodule

`default_nettype wire

@@ src/joystick_deadband_calibrate_map.sv @@
// ----------------------------------------------------------------------------
// joystick_deadband_calibrate_map: two-axis joystick conditioner
// Learns or loads a dead band per axis and maps samples to signed percent.
// ----------------------------------------------------------------------------
// Each input beat carries one operation: a sample, a calibration tick, a
// restart of calibration or a load of explicit bands, and each produces
// exactly one result beat. While auto calibration is on and not yet finished,
// samples widen the learned band per axis and ticks advance a saturating
// timer; the first sample after the timer reaches calibrate_ticks finishes
// calibration and reports the band. Otherwise a sample becomes a reading:
// zero inside the band, else the distance from the band edge times one
// hundred divided by the span to the axis limit, truncated toward zero and
// clamped to plus or minus one hundred, and zero for an axis whose span on
// either side is zero. The block works on one beat at a time. A reading
// passes operand setup, eight steps of the restoring divider that both
// axes run side by side, and the write of the output register; every
// other operation passes setup and the write. The write waits while the
// output register holds a result that the receiver still stalls. The
// sequencer is back in idle with the write, so a new beat is accepted only
// once the last result is written. A finished result sits in the output
// register, so the next beat is taken while it waits. Configuration writes
// are always ready and must be issued only while no beat is in flight.
`default_nettype none

module joystick_deadband_calibrate_map (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  jdcm_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  wire                            out_stall,
    output jdcm_pkg::out_item_t            out_item,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [jdcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [jdcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jdcm_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic    cfg_write;

    // Configuration is a simple register bank; a write to an index past the
    // last register is taken and dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_min  <= '0;
            cfg_reg.axis_max  <= {ANALOG_MAX, ANALOG_MAX};
            cfg_reg.auto_cal  <= 1'b1;
            cfg_reg.cal_ticks <= TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_AXIS_MIN_X:    cfg_reg.axis_min[0] <= cfg_data[ADC_BITS-1:0];
                CFG_AXIS_MAX_X:    cfg_reg.axis_max[0] <= cfg_data[ADC_BITS-1:0];
                CFG_AXIS_MIN_Y:    cfg_reg.axis_min[1] <= cfg_data[ADC_BITS-1:0];
                CFG_AXIS_MAX_Y:    cfg_reg.axis_max[1] <= cfg_data[ADC_BITS-1:0];
                CFG_AUTO_CAL:      cfg_reg.auto_cal    <= cfg_data[0];
                CFG_CALIBRATE_TKS: cfg_reg.cal_ticks   <= cfg_data[TICK_W-1:0];
                default:           cfg_reg.auto_cal    <= cfg_reg.auto_cal;
            endcase
        end
    end

    // The sequencer owns the handshakes; the datapath owns all payload.
    jdcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    jdcm_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_joystick_deadband_calibrate_map.sv @@
// ----------------------------------------------------------------------------
// tb_joystick_deadband_calibrate_map: self-checking bench of the joystick conditioner
// Drives operation beats through the valid/stall channels and predicts every
// result beat. The run covers band learning, the calibration timeout, band
// loads and percent mapping, under several axis and calibration settings.
// ----------------------------------------------------------------------------
module tb_joystick_deadband_calibrate_map;
    timeunit 1ns;
    timeprecision 1ps;

    import jdcm_pkg::*;

    // Mismatch lines beyond this count are tallied but not printed.
    localparam int MAX_REPORTS       = 40;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int LONG_HOLD_CYCLES  = 300;
    // Length of the tail wait once every expected result has arrived.
    localparam int TAIL_CYCLES       = 24;
    localparam int DRAIN_GUARD       = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_beat;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_beat;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    joystick_deadband_calibrate_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the conditioner. Lane 0 is the X axis, lane 1 the Y axis,
    // the same way the package orders its configuration lanes.
    // ------------------------------------------------------------------------
    logic [ADC_BITS-1:0] lim_min [2];
    logic [ADC_BITS-1:0] lim_max [2];
    bit                  learn_on;
    logic [TICK_W-1:0]   learn_ticks;

    logic [ADC_BITS-1:0] band_lo [2];
    logic [ADC_BITS-1:0] band_hi [2];
    bit                  cal_done;
    logic [TICK_W-1:0]   tick_count;
    bit                  have_reading;
    logic signed [7:0]   prev_pct [2];

    // Result beats that the block still owes, oldest first.
    out_item_t           pending_results [$];

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        in_item_t             beat;
        bit                   typed;
        out_item_t            want;
    } stim_row_t;

    stim_row_t directed_rows [$];

    // Run bookkeeping.
    int  fail_count;
    int  beats_sent;
    int  results_checked;
    int  n_readings;
    int  n_moves;
    int  n_cal_done;
    int  n_writes;
    int  holds_done;

    // Pacing knobs shared between the stimulus and the receiver process.
    bit  sender_idle_on;
    bit  rx_stall_on;
    bit  long_hold_req;
    int  burst_left;
    logic [ADC_BITS-1:0] prev_x;
    logic [ADC_BITS-1:0] prev_y;

    // ------------------------------------------------------------------------
    // Percent mapping of one axis. Integer division in SystemVerilog truncates
    // toward zero, which is exactly the rounding the block must follow. A band
    // edge past the axis limit gives a negative span; the quotient is taken
    // as it comes and only the clamp keeps it in range.
    // ------------------------------------------------------------------------
    function automatic logic signed [7:0] axis_percent(int v, int amin, int amax,
                                                       int lo, int hi);
        int span_lo;
        int span_hi;
        int q;
        span_lo = lo - amin;
        span_hi = amax - hi;
        if (v >= lo && v <= hi)
            return 8'sd0;
        if (span_lo == 0 || span_hi == 0)
            return 8'sd0;
        if (v < lo)
            q = ((v - lo) * PCT) / span_lo;
        else
            q = ((v - hi) * PCT) / span_hi;
        if (q > PCT)
            q = PCT;
        if (q < -PCT)
            q = -PCT;
        return 8'(q);
    endfunction

    // Advances the shadow state by one accepted beat and returns the result
    // beat the block must produce for it.
    function automatic out_item_t condition_beat(in_item_t b);
        out_item_t           r;
        logic [ADC_BITS-1:0] raw [2];
        logic signed [7:0]   pct [2];
        bit                  learning;
        raw[0]   = b.raw_x;
        raw[1]   = b.raw_y;
        r        = '0;
        r.kind   = KIND_ACK;
        learning = learn_on && !cal_done;
        case (b.op)
            OP_SAMPLE:
            begin
                if (learning) begin
                    if (tick_count >= learn_ticks) begin
                        // The closing sample does not widen the band.
                        cal_done   = 1'b1;
                        tick_count = '0;
                        r.kind     = KIND_CAL_DONE;
                    end else begin
                        for (int a = 0; a < 2; a++) begin
                            if (raw[a] > band_hi[a])
                                band_hi[a] = raw[a];
                            if (raw[a] < band_lo[a])
                                band_lo[a] = raw[a];
                        end
                    end
                end else begin
                    for (int a = 0; a < 2; a++)
                        pct[a] = axis_percent(raw[a], lim_min[a], lim_max[a],
                                              band_lo[a], band_hi[a]);
                    r.kind       = KIND_READING;
                    r.value_x    = b.raw_x;
                    r.value_y    = b.raw_y;
                    r.position_x = pct[0];
                    r.position_y = pct[1];
                    r.button_out = b.button_in;
                    if (!have_reading || pct[0] != prev_pct[0] || pct[1] != prev_pct[1]) begin
                        r.moved     = 1'b1;
                        prev_pct[0] = pct[0];
                        prev_pct[1] = pct[1];
                    end
                    have_reading = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (learning && tick_count != TICK_MAX)
                    tick_count = tick_count + 1'b1;
            end
            OP_RESTART:
            begin
                cal_done   = 1'b0;
                tick_count = '0;
            end
            OP_LOAD:
            begin
                band_lo[0] = b.load_min_x;
                band_hi[0] = b.load_max_x;
                band_lo[1] = b.load_min_y;
                band_hi[1] = b.load_max_y;
            end
        endcase
        r.is_calibrated = cal_done;
        r.band_min_x    = band_lo[0];
        r.band_max_x    = band_hi[0];
        r.band_min_y    = band_lo[1];
        r.band_max_y    = band_hi[1];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat builders.
    // ------------------------------------------------------------------------
    function automatic in_item_t scramble();
        logic [63:0] bits;
        in_item_t    b;
        bits = {$urandom(), $urandom()};
        b    = bits[$bits(in_item_t)-1:0];
        return b;
    endfunction

    function automatic in_item_t sample_of(int x, int y, bit btn);
        in_item_t b;
        b           = '0;
        b.op        = OP_SAMPLE;
        b.raw_x     = 10'(x);
        b.raw_y     = 10'(y);
        b.button_in = btn;
        return b;
    endfunction

    function automatic in_item_t op_only(logic [1:0] op);
        in_item_t b;
        b    = '0;
        b.op = op;
        return b;
    endfunction

    function automatic in_item_t load_of(int lx, int hx, int ly, int hy);
        in_item_t b;
        b            = '0;
        b.op         = OP_LOAD;
        b.load_min_x = 10'(lx);
        b.load_max_x = 10'(hx);
        b.load_min_y = 10'(ly);
        b.load_max_y = 10'(hy);
        return b;
    endfunction

    function automatic out_item_t result_beat(logic [1:0] k, int vx, int vy, int px, int py,
                                              bit bo, bit cal, bit mv,
                                              int lx, int hx, int ly, int hy);
        out_item_t r;
        r.kind          = k;
        r.value_x       = 10'(vx);
        r.value_y       = 10'(vy);
        r.position_x    = 8'(px);
        r.position_y    = 8'(py);
        r.button_out    = bo;
        r.is_calibrated = cal;
        r.moved         = mv;
        r.band_min_x    = 10'(lx);
        r.band_max_x    = 10'(hx);
        r.band_min_y    = 10'(ly);
        r.band_max_y    = 10'(hy);
        return r;
    endfunction

    // Raw values lean toward the rails, the stick center and repeats, so that
    // clamping, the dead band and the unchanged-position case all come up.
    function automatic logic [ADC_BITS-1:0] pick_raw(logic [ADC_BITS-1:0] last);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ANALOG_MAX;
            2:       return last;
            3, 4:    return 10'($urandom_range(380, 640));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic in_item_t reading_beat();
        in_item_t b;
        b       = scramble();
        b.op    = OP_SAMPLE;
        b.raw_x = pick_raw(prev_x);
        b.raw_y = pick_raw(prev_y);
        prev_x  = b.raw_x;
        prev_y  = b.raw_y;
        return b;
    endfunction

    function automatic in_item_t center_sample();
        in_item_t b;
        b       = scramble();
        b.op    = OP_SAMPLE;
        b.raw_x = 10'($urandom_range(420, 600));
        b.raw_y = 10'($urandom_range(420, 600));
        return b;
    endfunction

    // Sender pacing: bursts of random length separated by random gaps.
    function automatic int next_gap();
        if (!sender_idle_on)
            return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 24);
        return $urandom_range(1, 12);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, int val);
        stim_row_t r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = 16'(val);
        r.beat     = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_beat(in_item_t b);
        stim_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.beat     = b;
        r.typed    = 1'b0;
        r.want     = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_checked(in_item_t b, out_item_t w);
        stim_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.beat     = b;
        r.typed    = 1'b1;
        r.want     = w;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Everything the bench drives changes on the falling
    // edge, so the block always sees settled inputs at the rising edge.
    // ------------------------------------------------------------------------

    // Offers one beat and returns at the rising edge that accepts it. The
    // expectation is queued right there; the result still has to pass setup
    // and the output write, so queue order always matches beat order.
    task automatic offer_beat(in_item_t b, bit use_typed, out_item_t typed);
        int        gap;
        out_item_t predicted;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = condition_beat(b);
        pending_results.push_back(use_typed ? typed : predicted);
        beats_sent++;
        if (predicted.kind == KIND_READING)
            n_readings++;
        if (predicted.kind == KIND_CAL_DONE)
            n_cal_done++;
        if (predicted.moved)
            n_moves++;
    endtask

    // Every beat yields exactly one result, so an empty queue means the block
    // is idle. A few spare cycles let the last output handshake settle.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_AXIS_MIN_X:    lim_min[0]  = val[ADC_BITS-1:0];
            CFG_AXIS_MAX_X:    lim_max[0]  = val[ADC_BITS-1:0];
            CFG_AXIS_MIN_Y:    lim_min[1]  = val[ADC_BITS-1:0];
            CFG_AXIS_MAX_Y:    lim_max[1]  = val[ADC_BITS-1:0];
            CFG_AUTO_CAL:      learn_on    = val[0];
            CFG_CALIBRATE_TKS: learn_ticks = val;
            default:           ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Most of it is well-formed: a restart, a handful of samples
    // near the stick center to grow the band, ticks that mostly reach a short
    // timeout, then readings (the first one closes calibration if the timeout
    // was reached). Band loads with readings, bare readings and fully random
    // beats fill in the rest. Every field of every beat starts out random.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(int quota);
        int       done_n;
        int       n;
        int       nt;
        in_item_t b;
        done_n = 0;
        while (done_n < quota) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    b    = scramble();
                    b.op = OP_RESTART;
                    offer_beat(b, 1'b0, '0);
                    done_n++;
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++) begin
                        offer_beat(center_sample(), 1'b0, '0);
                        done_n++;
                    end
                    // Sometimes one tick short, sometimes a couple over.
                    if (learn_ticks <= 40)
                        nt = int'(learn_ticks) + $urandom_range(0, 2) - ($urandom_range(0, 5) == 0);
                    else
                        nt = $urandom_range(0, 3);
                    for (int i = 0; i < nt; i++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            offer_beat(center_sample(), 1'b0, '0);
                            done_n++;
                        end
                        b    = scramble();
                        b.op = OP_TICK;
                        offer_beat(b, 1'b0, '0);
                        done_n++;
                    end
                    n = $urandom_range(4, 14);
                    for (int i = 0; i <= n; i++) begin
                        offer_beat(reading_beat(), 1'b0, '0);
                        done_n++;
                    end
                end
                5, 6:
                begin
                    b    = scramble();
                    b.op = OP_LOAD;
                    // Mostly an ordinary band around the center; otherwise
                    // whatever random edges came out, inverted ones included.
                    if ($urandom_range(0, 5) != 0) begin
                        b.load_min_x = 10'($urandom_range(200, 520));
                        b.load_max_x = b.load_min_x + 10'($urandom_range(0, 300));
                        b.load_min_y = 10'($urandom_range(200, 520));
                        b.load_max_y = b.load_min_y + 10'($urandom_range(0, 300));
                    end
                    offer_beat(b, 1'b0, '0);
                    done_n++;
                    n = $urandom_range(3, 12);
                    for (int i = 0; i < n; i++) begin
                        offer_beat(reading_beat(), 1'b0, '0);
                        done_n++;
                    end
                end
                7, 8:
                begin
                    n = $urandom_range(2, 10);
                    for (int i = 0; i < n; i++) begin
                        offer_beat(reading_beat(), 1'b0, '0);
                        done_n++;
                    end
                end
                default:
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        offer_beat(scramble(), 1'b0, '0);
                        done_n++;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic signed [31:0] want_v,
                               logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
        end
    endtask

    out_item_t want;

    // Result beats are taken at the rising edge, before the block updates,
    // and each is compared field by field with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected, expected none, actual %p",
                             $time, out_beat);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("kind",          want.kind,          out_beat.kind);
                check_field("value_x",       want.value_x,       out_beat.value_x);
                check_field("value_y",       want.value_y,       out_beat.value_y);
                check_field("position_x",    $signed(want.position_x),
                            $signed(out_beat.position_x));
                check_field("position_y",    $signed(want.position_y),
                            $signed(out_beat.position_y));
                check_field("button_out",    want.button_out,    out_beat.button_out);
                check_field("is_calibrated", want.is_calibrated, out_beat.is_calibrated);
                check_field("moved",         want.moved,         out_beat.moved);
                check_field("band_min_x",    want.band_min_x,    out_beat.band_min_x);
                check_field("band_max_x",    want.band_max_x,    out_beat.band_max_x);
                check_field("band_min_y",    want.band_min_y,    out_beat.band_min_y);
                check_field("band_max_y",    want.band_max_y,    out_beat.band_max_y);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clock, receiver and watchdog.
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver runs in segments, each with its own stall pattern: none,
    // sparse random, periodic or heavy random. When asked, it instead holds
    // off for one long stretch that it counts itself, so the output register
    // fills and the block has to stall its input.
    initial begin : receiver
        int seg_len;
        int seg_mode;
        out_stall = 1'b0;
        forever begin
            if (long_hold_req) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_req = 1'b0;
                holds_done++;
            end else begin
                seg_len  = $urandom_range(4, 48);
                seg_mode = rx_stall_on ? $urandom_range(0, 3) : 0;
                for (int k = 0; k < seg_len; k++) begin
                    @(negedge clk);
                    case (seg_mode)
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= (k % 4 == 3);
                        3:       out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= 1'b0;
                    endcase
                end
            end
        end
    end

    // The slowest correct run stays well under 5 ms; this is several times that.
    initial begin : watchdog
        #20ms;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int waited;
        int lmin [2];
        int lmax [2];
        int au;
        int tk;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Shadow state as the block comes out of reset: the band starts empty
        // so that the first samples can open it from both sides.
        lim_min[0]   = '0;
        lim_max[0]   = ANALOG_MAX;
        lim_min[1]   = '0;
        lim_max[1]   = ANALOG_MAX;
        learn_on     = 1'b1;
        learn_ticks  = TICKS_RST;
        band_lo[0]   = ANALOG_MAX;
        band_hi[0]   = '0;
        band_lo[1]   = ANALOG_MAX;
        band_hi[1]   = '0;
        cal_done     = 1'b0;
        tick_count   = '0;
        have_reading = 1'b0;
        prev_pct[0]  = '0;
        prev_pct[1]  = '0;

        sender_idle_on = 1'b1;
        rx_stall_on    = 1'b1;
        long_hold_req  = 1'b0;
        burst_left     = 0;
        prev_x         = 10'd512;
        prev_y         = 10'd512;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Rows whose result is plain from the spec carry it
        // typed in; the rest go through the shadow model.
        // Reset settings: a tick during learning only bumps the timer.
        add_checked(op_only(OP_TICK),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 1023, 0, 1023, 0));
        // The first sample opens the empty band on both sides at once.
        add_checked(sample_of(512, 300, 1),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 512, 512, 300, 300));
        add_checked(sample_of(0, 1023, 1),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 512, 300, 1023));
        add_checked(sample_of(1023, 0, 0),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 0, 1023));
        // Zero timeout: the next sample ends learning without touching the band.
        add_write(CFG_CALIBRATE_TKS, 0);
        add_checked(sample_of(700, 300, 1),
                    result_beat(KIND_CAL_DONE, 0, 0, 0, 0, 0, 1, 0, 0, 1023, 0, 1023));
        // A tick after calibration is ignored.
        add_checked(op_only(OP_TICK),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 1, 0, 0, 1023, 0, 1023));
        // The band spans the whole axis, and the first reading always moves.
        add_checked(sample_of(700, 300, 1),
                    result_beat(KIND_READING, 700, 300, 0, 0, 1, 1, 1, 0, 1023, 0, 1023));
        add_checked(load_of(400, 600, 450, 550),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 1, 0, 400, 600, 450, 550));
        // Rails map to the full percent on each side.
        add_checked(sample_of(0, 1023, 0),
                    result_beat(KIND_READING, 0, 1023, -100, 100, 0, 1, 1, 400, 600, 450, 550));
        add_checked(sample_of(1023, 0, 1),
                    result_beat(KIND_READING, 1023, 0, 100, -100, 1, 1, 1, 400, 600, 450, 550));
        add_beat(sample_of(500, 500, 0));
        add_beat(sample_of(500, 500, 0));
        add_beat(sample_of(300, 700, 1));
        // An inverted X band and an empty Y band hold no raw value at all.
        add_checked(load_of(600, 400, 1023, 0),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 1, 0, 600, 400, 1023, 0));
        add_beat(sample_of(500, 500, 0));
        add_beat(sample_of(700, 1000, 1));
        // Zero spans: the X low edge sits on the axis minimum and the Y high
        // edge on the axis maximum.
        add_write(CFG_AXIS_MIN_X, 600);
        add_write(CFG_AXIS_MAX_Y, 0);
        add_beat(sample_of(100, 900, 0));
        // Negative spans: band edges lie beyond the axis limits.
        add_checked(load_of(100, 200, 100, 900),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 1, 0, 100, 200, 100, 900));
        add_beat(sample_of(0, 1023, 1));
        add_beat(sample_of(1023, 0, 0));
        // With auto calibration off, a restart leaves the block mapping.
        add_write(CFG_AUTO_CAL, 0);
        add_checked(op_only(OP_RESTART),
                    result_beat(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 100, 200, 100, 900));
        add_beat(sample_of(150, 50, 1));
        add_write(CFG_AXIS_MAX_X, 0);
        add_write(CFG_AXIS_MIN_Y, 1023);
        add_beat(sample_of(1023, 0, 1));
        // A restart keeps the band, and learning widens it further.
        add_write(CFG_AUTO_CAL, 1);
        add_write(CFG_CALIBRATE_TKS, 65535);
        add_beat(op_only(OP_RESTART));
        add_beat(sample_of(5, 1000, 0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                settle_block();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                offer_beat(directed_rows[i].beat, directed_rows[i].typed,
                           directed_rows[i].want);
            end
        end

        // Random phases, each under its own settings.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:
                begin
                    lmin = '{0, 0};
                    lmax = '{1023, 1023};
                    au   = 1;
                    tk   = 8;
                end
                1:
                begin
                    lmin = '{$urandom_range(0, 200), $urandom_range(0, 200)};
                    lmax = '{$urandom_range(800, 1023), $urandom_range(800, 1023)};
                    au   = 1;
                    tk   = $urandom_range(0, 20);
                end
                2:
                begin
                    lmin = '{0, 0};
                    lmax = '{1023, 1023};
                    au   = 0;
                    tk   = int'(TICKS_RST);
                end
                3:
                begin
                    // Axis limits turned inside out.
                    lmin = '{1023, 1023};
                    lmax = '{0, 0};
                    au   = 1;
                    tk   = 0;
                end
                4:
                begin
                    lmin = '{$urandom_range(0, 1023), $urandom_range(0, 1023)};
                    lmax = '{$urandom_range(0, 1023), $urandom_range(0, 1023)};
                    au   = $urandom_range(0, 1);
                    tk   = $urandom_range(0, 40);
                end
                5:
                begin
                    lmin = '{0, 0};
                    lmax = '{1023, 1023};
                    au   = 1;
                    tk   = 4;
                end
                default:
                begin
                    lmin = '{$urandom_range(0, 100), $urandom_range(0, 100)};
                    lmax = '{$urandom_range(900, 1023), $urandom_range(900, 1023)};
                    au   = 1;
                    tk   = $urandom_range(0, 12);
                end
            endcase
            settle_block();
            write_reg(CFG_AXIS_MIN_X, 16'(lmin[0]));
            write_reg(CFG_AXIS_MAX_X, 16'(lmax[0]));
            write_reg(CFG_AXIS_MIN_Y, 16'(lmin[1]));
            write_reg(CFG_AXIS_MAX_Y, 16'(lmax[1]));
            write_reg(CFG_AUTO_CAL, 16'(au));
            write_reg(CFG_CALIBRATE_TKS, 16'(tk));
            // In one phase the sender streams back to back while the receiver
            // takes its long hold-off.
            if (p == 5) begin
                sender_idle_on = 1'b0;
                long_hold_req  = 1'b1;
            end
            run_random_phase(200);
            sender_idle_on = 1'b1;
        end

        // Let the last results drain, then give the pipeline time to show
        // anything it should not have produced.
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_GUARD) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0t: %0d result beats never arrived, expected %p, actual none",
                     $time, pending_results.size(), pending_results[0]);
        end

        $display("Sent %0d beats under %0d register writes;",
                 beats_sent, n_writes);
        $display("compared %0d results: %0d readings, %0d moves, %0d calibration ends, %0d long holds.",
                 results_checked, n_readings, n_moves, n_cal_done, holds_done);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
